/* rtl/bcp_pkg.sv */
// bcp_pkg: shared types and constants of the barometer conversion poller
// no dependencies

package bcp_pkg;

  localparam int unsigned AltW     = 20;
  localparam int unsigned TempW    = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned MsW      = 16;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned InDataW  = 88;
  localparam int unsigned OutDataW = 48;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 20;

  // status register bit that flags new data
  localparam int unsigned DrdyBit = 3;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegBaroEnable = 3'd0;
  localparam logic [CfgIdxW-1:0] RegConvTime   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegTimeout    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegAltMin     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegAltMax     = 3'd4;
  localparam logic [CfgIdxW-1:0] RegTempMin    = 3'd5;
  localparam logic [CfgIdxW-1:0] RegTempMax    = 3'd6;

  // reset values
  localparam logic [MsW-1:0]          ConvTimeRst = 16'd10;
  localparam logic [MsW-1:0]          TimeoutRst  = 16'd100;
  localparam logic signed [AltW-1:0]  AltMinRst   = -20'sd524288;
  localparam logic signed [AltW-1:0]  AltMaxRst   = 20'sd524287;
  localparam logic signed [TempW-1:0] TempMinRst  = -16'sd32768;
  localparam logic signed [TempW-1:0] TempMaxRst  = 16'sd32767;
  localparam logic signed [AltW-1:0]  HeldAltRst  = '0;
  localparam logic signed [TempW-1:0] HeldTempRst = 16'sd6400;

  typedef struct packed {
    logic                    baro_enable;
    logic [MsW-1:0]          conv_time_ms;
    logic [MsW-1:0]          timeout_ms;
    logic signed [AltW-1:0]  alt_min;
    logic signed [AltW-1:0]  alt_max;
    logic signed [TempW-1:0] temp_min;
    logic signed [TempW-1:0] temp_max;
  } cfg_t;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic             status_ok;
    logic [ByteW-1:0] status_reg;
    logic             data_ok;
    logic [ByteW-1:0] alt_msb;
    logic [ByteW-1:0] alt_csb;
    logic [ByteW-1:0] alt_lsb;
    logic [ByteW-1:0] temp_msb;
    logic [ByteW-1:0] temp_lsb;
  } poll_t;

  typedef struct packed {
    logic                    poll_ok;
    logic                    start_conversion;
    logic signed [AltW-1:0]  altitude;
    logic signed [TempW-1:0] temperature;
    logic                    new_sample;
    logic                    range_fault;
    logic                    timed_out;
  } res_t;

endpackage

/* rtl/bcp_cfg_regs.sv */
// bcp_cfg_regs: configuration register file, write only
// depends on bcp_pkg

module bcp_cfg_regs
  import bcp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegBaroEnable: cfg_d.baro_enable  = cfg_wdata_i[0];
        RegConvTime:   cfg_d.conv_time_ms = cfg_wdata_i[MsW-1:0];
        RegTimeout:    cfg_d.timeout_ms   = cfg_wdata_i[MsW-1:0];
        RegAltMin:     cfg_d.alt_min      = cfg_wdata_i[AltW-1:0];
        RegAltMax:     cfg_d.alt_max      = cfg_wdata_i[AltW-1:0];
        RegTempMin:    cfg_d.temp_min     = cfg_wdata_i[TempW-1:0];
        RegTempMax:    cfg_d.temp_max     = cfg_wdata_i[TempW-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.baro_enable  <= 1'b0;
      cfg_q.conv_time_ms <= ConvTimeRst;
      cfg_q.timeout_ms   <= TimeoutRst;
      cfg_q.alt_min      <= AltMinRst;
      cfg_q.alt_max      <= AltMaxRst;
      cfg_q.temp_min     <= TempMinRst;
      cfg_q.temp_max     <= TempMaxRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/bcp_poll_core.sv */
// bcp_poll_core: trigger state, elapsed time checks, unpack and range check
// depends on bcp_pkg

module bcp_poll_core
  import bcp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  step_i,
  input  poll_t poll_i,
  output res_t  res_o,
  output logic  armed_o
);

  logic                    armed_q, armed_d;
  logic [TimeW-1:0]        trig_q, trig_d;
  logic signed [AltW-1:0]  alt_q, alt_d;
  logic signed [TempW-1:0] temp_q, temp_d;

  logic [TimeW-1:0]        elapsed;
  logic                    conv_done, past_timeout, drdy, in_range;
  logic signed [AltW-1:0]  alt_raw;
  logic signed [TempW-1:0] temp_raw;

  assign elapsed      = poll_i.now_ms - trig_q;
  assign conv_done    = elapsed >= {{(TimeW-MsW){1'b0}}, cfg_i.conv_time_ms};
  assign past_timeout = elapsed > {{(TimeW-MsW){1'b0}}, cfg_i.timeout_ms};
  assign drdy         = poll_i.status_ok && poll_i.status_reg[DrdyBit];
  assign alt_raw      = {poll_i.alt_msb, poll_i.alt_csb, poll_i.alt_lsb[ByteW-1:4]};
  assign temp_raw     = {poll_i.temp_msb, poll_i.temp_lsb};
  assign in_range     = (alt_raw >= cfg_i.alt_min) && (alt_raw <= cfg_i.alt_max) &&
                        (temp_raw >= cfg_i.temp_min) && (temp_raw <= cfg_i.temp_max);

  always_comb begin
    armed_d = armed_q;
    trig_d  = trig_q;
    alt_d   = alt_q;
    temp_d  = temp_q;
    res_o   = '0;
    if (cfg_i.baro_enable) begin
      res_o.poll_ok = 1'b1;
      if (!armed_q) begin
        res_o.start_conversion = 1'b1;
        armed_d = 1'b1;
        trig_d  = poll_i.now_ms;
      end else if (conv_done) begin
        if (!drdy) begin
          if (past_timeout) begin
            armed_d         = 1'b0;
            res_o.timed_out = 1'b1;
          end
        end else begin
          armed_d = 1'b0;
          if (poll_i.data_ok) begin
            if (in_range) begin
              alt_d            = alt_raw;
              temp_d           = temp_raw;
              res_o.new_sample = 1'b1;
            end else begin
              res_o.range_fault = 1'b1;
            end
          end
        end
      end
    end
    // outputs show the held values after this poll
    res_o.altitude    = alt_d;
    res_o.temperature = temp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
      trig_q  <= '0;
      alt_q   <= HeldAltRst;
      temp_q  <= HeldTempRst;
    end else if (step_i) begin
      armed_q <= armed_d;
      trig_q  <= trig_d;
      alt_q   <= alt_d;
      temp_q  <= temp_d;
    end
  end

  assign armed_o = armed_q;

endmodule

/* rtl/barometer_conversion_poller.sv */
// barometer_conversion_poller: one poll request in, one result out, every cycle
// while m_axis_tready does not stall the output; a poll is registered at the input, then its result;
// throughput 1 poll per cycle, set by the single trigger state update in bcp_poll_core
// async active-low reset: not armed, trigger time 0, altitude 0, temperature 25 degC,
// config at defaults (disabled)
// depends on bcp_pkg, bcp_cfg_regs, bcp_poll_core

module barometer_conversion_poller
  import bcp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // now_ms[31:0] status_ok[32] status_reg[40:33] data_ok[41] alt_msb[49:42]
  // alt_csb[57:50] alt_lsb[65:58] temp_msb[73:66] temp_lsb[81:74] zero[87:82]
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // poll_ok[0] start_conversion[1] altitude[21:2] temperature[37:22]
  // new_sample[38] range_fault[39] timed_out[40] zero[47:41]
  output logic [OutDataW-1:0] m_axis_tdata
);

  cfg_t  cfg;
  poll_t poll_q;
  res_t  res, res_q;
  logic  in_v_q, out_v_q;
  logic  step, s_acc, m_acc, armed;

  bcp_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  // request in the input register moves on when the result slot frees up
  assign step          = in_v_q && (!out_v_q || m_axis_tready);
  assign s_axis_tready = !in_v_q || step;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign m_acc         = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s_acc)     in_v_q <= 1'b1;
      else if (step) in_v_q <= 1'b0;
      if (step)       out_v_q <= 1'b1;
      else if (m_acc) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      poll_q.now_ms     <= s_axis_tdata[31:0];
      poll_q.status_ok  <= s_axis_tdata[32];
      poll_q.status_reg <= s_axis_tdata[40:33];
      poll_q.data_ok    <= s_axis_tdata[41];
      poll_q.alt_msb    <= s_axis_tdata[49:42];
      poll_q.alt_csb    <= s_axis_tdata[57:50];
      poll_q.alt_lsb    <= s_axis_tdata[65:58];
      poll_q.temp_msb   <= s_axis_tdata[73:66];
      poll_q.temp_lsb   <= s_axis_tdata[81:74];
    end
    if (step) res_q <= res;
  end

  bcp_poll_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (step),
    .poll_i (poll_q),
    .res_o  (res),
    .armed_o(armed)
  );

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {7'd0, res_q.timed_out, res_q.range_fault, res_q.new_sample,
                          res_q.temperature, res_q.altitude, res_q.start_conversion,
                          res_q.poll_ok};

  // a trigger poll never also reports data or a timeout
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && res.start_conversion |-> !res.new_sample && !res.range_fault && !res.timed_out)
    else $error("trigger poll carries a data or timeout flag");

  // any flag implies the block was enabled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (res_q.start_conversion || res_q.new_sample || res_q.range_fault ||
                      res_q.timed_out) |-> res_q.poll_ok)
    else $error("flag raised on a disabled poll");

  // a trigger arms the block, a sample, fault or timeout disarms it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && res.start_conversion |=> armed)
    else $error("trigger did not arm");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && (res.new_sample || res.range_fault || res.timed_out) |=> !armed)
    else $error("completed poll left the block armed");

endmodule

/* verif/tb_barometer_conversion_poller.sv */
// testbench for barometer_conversion_poller: directed and random polls, checked per field
// against a cycle-free predictor kept in a small scoreboard class
// depends on bcp_pkg and barometer_conversion_poller
`timescale 1ns / 100ps

module tb_barometer_conversion_poller;
  import bcp_pkg::*;

  localparam logic [ByteW-1:0] StReady = 8'h08;
  localparam logic [ByteW-1:0] StBusy  = 8'hF7;
  localparam logic [TimeW-1:0] T0      = 32'hFFFF_FFFA;
  localparam int unsigned RandPerPhase = 245;
  localparam int unsigned DrainLimit   = 20000;

  // predicted sensor state and the results still owed by the block
  class poll_result_board;
    cfg_t                    regs;
    logic                    armed;
    logic [TimeW-1:0]        trigger_ms;
    logic signed [AltW-1:0]  held_alt;
    logic signed [TempW-1:0] held_temp;
    res_t                    pending_results[$];
    int unsigned             mismatches;
    int unsigned             results_seen;

    function new();
      regs.baro_enable  = 1'b0;
      regs.conv_time_ms = ConvTimeRst;
      regs.timeout_ms   = TimeoutRst;
      regs.alt_min      = AltMinRst;
      regs.alt_max      = AltMaxRst;
      regs.temp_min     = TempMinRst;
      regs.temp_max     = TempMaxRst;
      armed        = 1'b0;
      trigger_ms   = '0;
      held_alt     = HeldAltRst;
      held_temp    = HeldTempRst;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        RegBaroEnable: regs.baro_enable  = data[0];
        RegConvTime:   regs.conv_time_ms = data[MsW-1:0];
        RegTimeout:    regs.timeout_ms   = data[MsW-1:0];
        RegAltMin:     regs.alt_min      = data[AltW-1:0];
        RegAltMax:     regs.alt_max      = data[AltW-1:0];
        RegTempMin:    regs.temp_min     = data[TempW-1:0];
        RegTempMax:    regs.temp_max     = data[TempW-1:0];
        default: ;
      endcase
    endfunction

    function res_t predict_poll(poll_t p);
      res_t                    r;
      logic [TimeW-1:0]        elapsed;
      logic signed [AltW-1:0]  alt;
      logic signed [TempW-1:0] tmp;
      r = '0;
      if (regs.baro_enable) begin
        r.poll_ok = 1'b1;
        if (!armed) begin
          r.start_conversion = 1'b1;
          armed = 1'b1;
          trigger_ms = p.now_ms;
        end else begin
          elapsed = p.now_ms - trigger_ms;
          if (elapsed >= 32'(regs.conv_time_ms)) begin
            if (!p.status_ok || !p.status_reg[DrdyBit]) begin
              if (elapsed > 32'(regs.timeout_ms)) begin
                armed = 1'b0;
                r.timed_out = 1'b1;
              end
            end else begin
              if (p.data_ok) begin
                alt = {p.alt_msb, p.alt_csb, p.alt_lsb[7:4]};
                tmp = {p.temp_msb, p.temp_lsb};
                if (alt >= $signed(regs.alt_min) && alt <= $signed(regs.alt_max) &&
                    tmp >= $signed(regs.temp_min) && tmp <= $signed(regs.temp_max)) begin
                  held_alt  = alt;
                  held_temp = tmp;
                  r.new_sample = 1'b1;
                end else begin
                  r.range_fault = 1'b1;
                end
              end
              armed = 1'b0;
            end
          end
        end
      end
      r.altitude    = held_alt;
      r.temperature = held_temp;
      return r;
    endfunction

    function void note_poll(poll_t p);
      pending_results.push_back(predict_poll(p));
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      // keep the log short when the block is badly off
      if (mismatches <= 40)
        $display("mismatch at result %0d: %s got %0h want %0h", results_seen, what, got, want);
    endtask

    task check_result(res_t got);
      res_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        report("result with no poll outstanding", 32'(got.poll_ok), 32'd0);
        return;
      end
      want = pending_results.pop_front();
      if (got.poll_ok !== want.poll_ok)
        report("poll_ok", 32'(got.poll_ok), 32'(want.poll_ok));
      if (got.start_conversion !== want.start_conversion)
        report("start_conversion", 32'(got.start_conversion), 32'(want.start_conversion));
      if (got.altitude !== want.altitude)
        report("altitude", 32'(got.altitude), 32'(want.altitude));
      if (got.temperature !== want.temperature)
        report("temperature", 32'(got.temperature), 32'(want.temperature));
      if (got.new_sample !== want.new_sample)
        report("new_sample", 32'(got.new_sample), 32'(want.new_sample));
      if (got.range_fault !== want.range_fault)
        report("range_fault", 32'(got.range_fault), 32'(want.range_fault));
      if (got.timed_out !== want.timed_out)
        report("timed_out", 32'(got.timed_out), 32'(want.timed_out));
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // now_ms, status_ok, status_reg, data_ok, alt_msb, alt_csb, alt_lsb, temp_msb, temp_lsb
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // poll_ok, start_conversion, altitude, temperature, new_sample, range_fault, timed_out
  logic [OutDataW-1:0] m_axis_tdata;

  poll_result_board sb = new();
  int unsigned      tx_idle_pct;
  int unsigned      rx_idle_pct;
  logic             rx_hold;
  logic [TimeW-1:0] last_ms;

  barometer_conversion_poller dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [InDataW-1:0] pack_poll(poll_t p);
    return {6'b0, p.temp_lsb, p.temp_msb, p.alt_lsb, p.alt_csb, p.alt_msb,
            p.data_ok, p.status_reg, p.status_ok, p.now_ms};
  endfunction

  function automatic res_t unpack_result(logic [OutDataW-1:0] d);
    res_t r;
    r.poll_ok          = d[0];
    r.start_conversion = d[1];
    r.altitude         = d[21:2];
    r.temperature      = d[37:22];
    r.new_sample       = d[38];
    r.range_fault      = d[39];
    r.timed_out        = d[40];
    return r;
  endfunction

  // the low nibble of alt_lsb carries no altitude, so it gets random bits
  function automatic poll_t make_poll(logic [TimeW-1:0] now, logic sok, logic [ByteW-1:0] sbyte,
                                      logic dok, logic [AltW-1:0] alt, logic [TempW-1:0] tmp);
    poll_t p;
    p.now_ms     = now;
    p.status_ok  = sok;
    p.status_reg = sbyte;
    p.data_ok    = dok;
    p.alt_msb    = alt[19:12];
    p.alt_csb    = alt[11:4];
    p.alt_lsb    = {alt[3:0], 4'($urandom)};
    p.temp_msb   = tmp[15:8];
    p.temp_lsb   = tmp[7:0];
    return p;
  endfunction

  // mostly inside the window, some right on either side of it, some anywhere
  function automatic logic [AltW-1:0] pick_value(int lo, int hi);
    int unsigned pick = $urandom_range(99);
    if (pick < 60 && lo <= hi) return 20'(lo + int'($urandom_range(32'(hi - lo))));
    if (pick < 70) return 20'(lo - int'($urandom_range(1)));
    if (pick < 80) return 20'(hi + int'($urandom_range(1)));
    return 20'($urandom);
  endfunction

  // times are chosen around the predicted trigger time so the wait, ready and
  // timeout boundaries are all hit; a few polls land at a stray time
  function automatic poll_t random_poll();
    logic [TimeW-1:0] now;
    logic [TimeW-1:0] conv;
    logic [TimeW-1:0] tmo;
    logic [ByteW-1:0] sbyte;
    int unsigned      pick;
    conv = 32'(sb.regs.conv_time_ms);
    tmo  = 32'(sb.regs.timeout_ms);
    pick = $urandom_range(99);
    if (pick < 5) now = $urandom;
    else if (!sb.armed) now = last_ms + $urandom_range(1000);
    else if (pick < 15) now = sb.trigger_ms + (conv == 0 ? 32'd0 : $urandom_range(conv - 1));
    else if (pick < 30) now = sb.trigger_ms + conv;
    else if (pick < 42) now = sb.trigger_ms + tmo;
    else if (pick < 55) now = sb.trigger_ms + tmo + 32'd1;
    else now = sb.trigger_ms + conv + $urandom_range(40);
    last_ms = now;
    sbyte = 8'($urandom);
    sbyte[DrdyBit] = ($urandom_range(99) < 55);
    return make_poll(now, $urandom_range(9) != 0, sbyte, $urandom_range(6) != 0,
                     pick_value($signed(sb.regs.alt_min), $signed(sb.regs.alt_max)),
                     16'(pick_value($signed(sb.regs.temp_min), $signed(sb.regs.temp_max))));
  endfunction

  function automatic cfg_t random_cfg(int unsigned kind);
    cfg_t c;
    c.baro_enable = 1'b1;
    case (kind)
      0: begin
        c.conv_time_ms = 16'($urandom_range(20));
        c.timeout_ms   = 16'($urandom_range(150));
        c.alt_min      = 20'(-int'($urandom_range(524288)));
        c.alt_max      = 20'($urandom_range(524287));
        c.temp_min     = 16'(-int'($urandom_range(32768)));
        c.temp_max     = 16'($urandom_range(32767));
      end
      1: begin
        c.conv_time_ms = '1;
        c.timeout_ms   = '1;
        c.alt_min      = AltMinRst;
        c.alt_max      = AltMaxRst;
        c.temp_min     = TempMinRst;
        c.temp_max     = TempMaxRst;
      end
      default: begin
        // a narrow window that now and then wraps to min above max
        c.conv_time_ms = 16'($urandom);
        c.timeout_ms   = 16'($urandom);
        c.alt_min      = 20'($urandom);
        c.alt_max      = c.alt_min + 20'($urandom_range(65535));
        c.temp_min     = 16'($urandom);
        c.temp_max     = c.temp_min + 16'($urandom_range(4095));
      end
    endcase
    return c;
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  // unused upper bits of the write data carry junk
  task automatic apply_cfg(cfg_t c);
    write_reg(RegBaroEnable, {19'($urandom), c.baro_enable});
    write_reg(RegConvTime, {4'($urandom), c.conv_time_ms});
    write_reg(RegTimeout, {4'($urandom), c.timeout_ms});
    write_reg(RegAltMin, c.alt_min);
    write_reg(RegAltMax, c.alt_max);
    write_reg(RegTempMin, {4'($urandom), c.temp_min});
    write_reg(RegTempMax, {4'($urandom), c.temp_max});
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_poll(poll_t p);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pack_poll(p);
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_poll(p);
  endtask

  task automatic poll_at(logic [TimeW-1:0] now, logic sok, logic [ByteW-1:0] sbyte, logic dok,
                         logic [AltW-1:0] alt, logic [TempW-1:0] tmp);
    send_poll(make_poll(now, sok, sbyte, dok, alt, tmp));
  endtask

  task automatic drain();
    int unsigned waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rx_hold) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(unpack_result(m_axis_tdata));
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = RegBaroEnable;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    rx_hold       = 1'b0;
    tx_idle_pct   = 31;
    rx_idle_pct   = 81;
    last_ms       = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // disabled after reset, every field at its top value
    poll_at('1, 1'b1, 8'hFF, 1'b1, '1, '1);
    drain();
    apply_cfg('{baro_enable: 1'b1, conv_time_ms: 16'd10, timeout_ms: 16'd100,
                alt_min: -20'sd16, alt_max: 20'sd1600,
                temp_min: -16'sd2560, temp_max: 16'sd10240});
    // trigger just before the time counter wraps
    poll_at(T0, 1'b1, StBusy, 1'b1, '0, '0);
    poll_at(T0 + 32'd9, 1'b1, StReady, 1'b1, 20'd100, 16'd100);
    poll_at(T0 + 32'd10, 1'b0, StReady, 1'b1, 20'd100, 16'd100);
    poll_at(T0 + 32'd100, 1'b1, StBusy, 1'b1, '0, '0);
    poll_at(T0 + 32'd101, 1'b1, StBusy, 1'b1, '0, '0);
    poll_at(T0 + 32'd150, 1'b1, StBusy, 1'b1, '0, '0);
    // ready but the data read failed
    poll_at(T0 + 32'd160, 1'b1, StReady, 1'b0, 20'd100, 16'd100);
    poll_at(T0 + 32'd170, 1'b1, StBusy, 1'b1, '0, '0);
    poll_at(T0 + 32'd180, 1'b1, StReady, 1'b1, 20'd1600, 16'(-2560));
    poll_at(T0 + 32'd190, 1'b1, StBusy, 1'b1, '0, '0);
    poll_at(T0 + 32'd200, 1'b1, StReady, 1'b1, 20'd1601, 16'd0);
    poll_at(T0 + 32'd210, 1'b1, StBusy, 1'b1, '0, '0);
    poll_at(T0 + 32'd220, 1'b1, StReady, 1'b1, 20'(-16), 16'd10240);
    poll_at(T0 + 32'd230, 1'b1, StBusy, 1'b1, '0, '0);
    poll_at(T0 + 32'd240, 1'b1, StReady, 1'b1, 20'd0, 16'(-2561));
    drain();
    // zero wait and timeout, limits crossed so every reading faults
    apply_cfg('{baro_enable: 1'b1, conv_time_ms: 16'd0, timeout_ms: 16'd0,
                alt_min: AltMaxRst, alt_max: AltMinRst,
                temp_min: TempMinRst, temp_max: TempMaxRst});
    poll_at(32'd0, 1'b1, StBusy, 1'b1, '0, '0);
    poll_at(32'd0, 1'b1, 8'h00, 1'b1, '0, '0);
    poll_at(32'd1, 1'b1, 8'h00, 1'b1, '0, '0);
    poll_at(32'd2, 1'b1, StBusy, 1'b1, '0, '0);
    poll_at(32'd2, 1'b1, StReady, 1'b1, '0, '0);
    poll_at(32'd5, 1'b1, StBusy, 1'b1, '0, '0);
    drain();
    // disabled while armed: state must survive
    apply_cfg('{baro_enable: 1'b0, conv_time_ms: 16'hFFFF, timeout_ms: 16'hFFFF,
                alt_min: AltMinRst, alt_max: AltMaxRst,
                temp_min: TempMinRst, temp_max: TempMaxRst});
    poll_at(32'd7, 1'b1, 8'hFF, 1'b1, 20'd5, 16'd5);
    drain();
    apply_cfg('{baro_enable: 1'b1, conv_time_ms: 16'hFFFF, timeout_ms: 16'hFFFF,
                alt_min: AltMinRst, alt_max: AltMaxRst,
                temp_min: TempMinRst, temp_max: TempMaxRst});
    poll_at(32'd5 + 32'd65534, 1'b1, StReady, 1'b1, 20'd5, 16'd5);
    poll_at(32'd5 + 32'd65535, 1'b1, StReady, 1'b1, 20'h80000, 16'h7FFF);

    last_ms = 32'd5 + 32'd65535;
    for (int unsigned ph = 0; ph < 3; ph++) begin
      drain();
      case (ph)
        0: begin
          tx_idle_pct = 31;
          rx_idle_pct = 81;
        end
        1: begin
          tx_idle_pct = 81;
          rx_idle_pct = 31;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      apply_cfg(random_cfg(ph));
      repeat (RandPerPhase) send_poll(random_poll());
    end

    // output held off for a long stretch while polls keep coming
    drain();
    apply_cfg(random_cfg(0));
    fork
      begin
        rx_hold <= 1'b1;
        repeat (400) @(posedge clk_i);
        rx_hold <= 1'b0;
      end
      repeat (60) send_poll(random_poll());
    join

    drain();
    if (sb.pending_results.size() != 0)
      sb.report("results never returned", 32'(sb.pending_results.size()), 32'd0);
    if (sb.mismatches == 0) begin
      $display("[barometer_conversion_poller] OK");
    end else begin
      $display("[barometer_conversion_poller] ERROR");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("[barometer_conversion_poller] ERROR");
    $finish;
  end

endmodule

/* sim.f */
rtl/bcp_pkg.sv
rtl/bcp_cfg_regs.sv
rtl/bcp_poll_core.sv
rtl/barometer_conversion_poller.sv
verif/tb_barometer_conversion_poller.sv
